// File: design/string_literal_scanner_assert.svh
// Assertion macros for the string literal scanner.
`ifndef STRING_LITERAL_SCANNER_ASSERT_SVH
`define STRING_LITERAL_SCANNER_ASSERT_SVH

// Check that expr holds in the same cycle as cond.
`define SLS_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Check that expr holds in the cycle after cond.
`define SLS_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: design/sls_pkg.sv
// Package: types and constants of the string literal scanner.
package sls_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int FIELD_WIDTH = 16;

  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] SEP_LEAD   = 8'he2;
  localparam logic [7:0] SEP_MID    = 8'h80;
  localparam logic [7:0] SEP_LS     = 8'ha8;
  localparam logic [7:0] SEP_PS     = 8'ha9;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_BODY  = 3'd1,
    MODE_ESC   = 3'd2,
    MODE_UOPEN = 3'd3,
    MODE_BRACE = 3'd4,
    MODE_FIXED = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_SCAN   = 3'd1,
    ST_DONE   = 3'd2,
    ST_NOTLIT = 3'd3,
    ST_TERM   = 3'd4,
    ST_BADHEX = 3'd5
  } status_t;

  typedef struct packed {
    mode_t      mode;
    logic       quote_double;
    logic [2:0] hex_left;
    logic       last_under;
    logic [1:0] sep_step;
  } scan_state_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    mode: MODE_IDLE, quote_double: 1'b0, hex_left: 3'd0,
    last_under: 1'b0, sep_step: 2'd0
  };

endpackage

// File: design/string_literal_scanner.sv
// String literal scanner: one source byte per cycle in, one status word per
// byte out. A byte is taken every cycle while the result side keeps up; each
// accepted byte waits in the input register until the result register can take
// it; its word then appears on the result port, where the result register holds
// it until it is taken. The scan state and byte count update as a byte moves
// from the input register to the result register, and that update sets the
// rate of one byte per cycle. Offsets and lengths count from the opening
// quote and saturate.
module string_literal_scanner #(
  parameter int COUNT_WIDTH = sls_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            text_valid,
  output logic                            text_stall,
  input  logic [7:0]                      text_byte,
  input  logic                            starts_token,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [2:0]                      scan_status,
  output logic [sls_pkg::FIELD_WIDTH-1:0] token_length,
  output logic [sls_pkg::FIELD_WIDTH-1:0] error_offset
);
  import sls_pkg::*;

  `include "string_literal_scanner_assert.svh"

  logic                   hold_valid;
  logic [7:0]             hold_byte;
  logic                   hold_start;
  logic                   advance;
  logic                   load;

  scan_state_t            state;
  scan_state_t            state_next;
  logic [COUNT_WIDTH-1:0] bytes_seen;
  logic [COUNT_WIDTH-1:0] bytes_seen_next;

  status_t                step_status;
  logic [FIELD_WIDTH-1:0] step_length;
  logic [FIELD_WIDTH-1:0] step_offset;
  status_t                result_status;

  assign advance    = hold_valid && (!result_valid || !result_stall);
  assign text_stall = hold_valid && !advance;
  assign load       = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte  <= text_byte;
      hold_start <= starts_token;
    end
  end

  sls_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .state          (state),
    .bytes_seen     (bytes_seen),
    .text_byte      (hold_byte),
    .starts_token   (hold_start),
    .state_next     (state_next),
    .bytes_seen_next(bytes_seen_next),
    .status         (step_status),
    .length         (step_length),
    .offset         (step_offset)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SCAN_STATE_RESET;
      bytes_seen <= '0;
    end else if (advance) begin
      state      <= state_next;
      bytes_seen <= bytes_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_status <= step_status;
      token_length  <= step_length;
      error_offset  <= step_offset;
    end
  end

  assign scan_status = result_status;

  `SLS_ASSERT_NOW(a_stall_only_when_full, text_stall, hold_valid,
                  "stall with empty input register")
  `SLS_ASSERT_NOW(a_idle_count_clear, state.mode == MODE_IDLE, bytes_seen == '0,
                  "count not clear while idle")
  `SLS_ASSERT_NOW(a_done_length, result_valid && result_status == ST_DONE,
                  token_length >= FIELD_WIDTH'(2), "literal shorter than two quotes")
  `SLS_ASSERT_NEXT(a_advance_fills_result, advance, result_valid,
                   "result lost after advance")

endmodule

// File: design/sls_step.sv
// Next-state and result logic for one source byte of the scanner.
module sls_step #(
  parameter int COUNT_WIDTH = sls_pkg::COUNT_WIDTH_DEFAULT
) (
  input  sls_pkg::scan_state_t          state,
  input  logic [COUNT_WIDTH-1:0]        bytes_seen,
  input  logic [7:0]                    text_byte,
  input  logic                          starts_token,
  output sls_pkg::scan_state_t          state_next,
  output logic [COUNT_WIDTH-1:0]        bytes_seen_next,
  output sls_pkg::status_t              status,
  output logic [sls_pkg::FIELD_WIDTH-1:0] length,
  output logic [sls_pkg::FIELD_WIDTH-1:0] offset
);
  import sls_pkg::*;

  localparam int WIDE = (COUNT_WIDTH > FIELD_WIDTH) ? COUNT_WIDTH : FIELD_WIDTH;
  localparam logic [WIDE-1:0] FIELD_MAX = WIDE'({FIELD_WIDTH{1'b1}});

  logic                   is_hex;
  logic                   fail;
  logic                   count_full;
  logic [COUNT_WIDTH-1:0] len_raw;
  logic [COUNT_WIDTH-1:0] off_raw;
  logic [WIDE-1:0]        len_wide;
  logic [WIDE-1:0]        off_wide;
  logic [7:0]             close_quote;

  assign is_hex = (text_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  assign count_full = &bytes_seen;
  assign close_quote = state.quote_double ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    state_next      = state;
    bytes_seen_next = bytes_seen;
    status          = ST_IDLE;
    fail            = 1'b0;
    len_raw         = '0;
    off_raw         = '0;
    if (starts_token) begin
      state_next.mode       = MODE_IDLE;
      state_next.hex_left   = 3'd0;
      state_next.last_under = 1'b0;
      state_next.sep_step   = 2'd0;
      bytes_seen_next       = '0;
      if (text_byte == CH_SQUOTE || text_byte == CH_DQUOTE) begin
        state_next.mode         = MODE_BODY;
        state_next.quote_double = (text_byte == CH_DQUOTE);
        bytes_seen_next         = COUNT_WIDTH'(1);
        status                  = ST_SCAN;
      end else begin
        status = ST_NOTLIT;
      end
    end else if (state.mode != MODE_IDLE) begin
      status = ST_SCAN;
      case (state.mode)
        MODE_BODY: begin
          if (text_byte == CH_LF || text_byte == CH_CR || text_byte == CH_NUL) begin
            status  = ST_TERM;
            off_raw = bytes_seen;
            fail    = 1'b1;
          end else if (state.sep_step == 2'd2 &&
                       (text_byte == SEP_LS || text_byte == SEP_PS)) begin
            status  = ST_TERM;
            off_raw = (bytes_seen >= COUNT_WIDTH'(2)) ? bytes_seen - COUNT_WIDTH'(2) : '0;
            fail    = 1'b1;
          end else if (text_byte == CH_BSLASH) begin
            state_next.mode     = MODE_ESC;
            state_next.sep_step = 2'd0;
          end else if (text_byte == close_quote) begin
            status  = ST_DONE;
            len_raw = count_full ? bytes_seen : bytes_seen + COUNT_WIDTH'(1);
            fail    = 1'b1;
          end else if (text_byte == SEP_LEAD) begin
            state_next.sep_step = 2'd1;
          end else if (state.sep_step == 2'd1 && text_byte == SEP_MID) begin
            state_next.sep_step = 2'd2;
          end else begin
            state_next.sep_step = 2'd0;
          end
        end
        MODE_ESC: begin
          if (text_byte == CH_NUL) begin
            status  = ST_TERM;
            off_raw = bytes_seen;
            fail    = 1'b1;
          end else if (text_byte == CH_LOWER_U) begin
            state_next.mode = MODE_UOPEN;
          end else if (text_byte == CH_LOWER_X) begin
            state_next.mode     = MODE_FIXED;
            state_next.hex_left = 3'd2;
          end else begin
            state_next.mode = MODE_BODY;
          end
        end
        MODE_UOPEN: begin
          if (text_byte == CH_LBRACE) begin
            state_next.mode       = MODE_BRACE;
            state_next.last_under = 1'b0;
          end else if (is_hex) begin
            state_next.mode     = MODE_FIXED;
            state_next.hex_left = 3'd3;
          end else begin
            status  = ST_BADHEX;
            off_raw = bytes_seen;
            fail    = 1'b1;
          end
        end
        MODE_BRACE: begin
          if (is_hex) begin
            state_next.last_under = 1'b0;
          end else if (text_byte == CH_UNDER && !state.last_under) begin
            state_next.last_under = 1'b1;
          end else if (text_byte == CH_RBRACE) begin
            state_next.mode       = MODE_BODY;
            state_next.last_under = 1'b0;
          end else begin
            status  = ST_BADHEX;
            off_raw = bytes_seen;
            fail    = 1'b1;
          end
        end
        MODE_FIXED: begin
          if (is_hex) begin
            if (state.hex_left <= 3'd1) begin
              state_next.hex_left = 3'd0;
              state_next.mode     = MODE_BODY;
            end else begin
              state_next.hex_left = state.hex_left - 3'd1;
            end
          end else begin
            status  = ST_BADHEX;
            off_raw = bytes_seen;
            fail    = 1'b1;
          end
        end
        default: begin
          status = ST_IDLE;
          fail   = 1'b1;
        end
      endcase
      if (fail) begin
        state_next.mode       = MODE_IDLE;
        state_next.hex_left   = 3'd0;
        state_next.last_under = 1'b0;
        state_next.sep_step   = 2'd0;
        bytes_seen_next       = '0;
      end else if (!count_full) begin
        bytes_seen_next = bytes_seen + COUNT_WIDTH'(1);
      end
    end
  end

  assign len_wide = WIDE'(len_raw);
  assign off_wide = WIDE'(off_raw);
  assign length   = (len_wide > FIELD_MAX) ? '1 : len_wide[FIELD_WIDTH-1:0];
  assign offset   = (off_wide > FIELD_MAX) ? '1 : off_wide[FIELD_WIDTH-1:0];

endmodule

// File: bench/tb_string_literal_scanner.sv
// Self-checking bench for the string literal scanner: directed bytes, random literals, long runs.
`timescale 1ns / 1ps

module tb_string_literal_scanner;
  import sls_pkg::*;

  localparam int CW = COUNT_WIDTH_DEFAULT;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 90;

  typedef struct packed {
    status_t     status;
    logic [15:0] tok_len;
    logic [15:0] err_off;
  } scan_report_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       starts;
  } plan_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        starts;
    logic        typed;
    status_t     status;
    logic [15:0] tok_len;
    logic [15:0] err_off;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  logic [7:0]  text_byte = 8'h00;
  logic        starts_token = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [2:0]  scan_status;
  logic [15:0] token_length;
  logic [15:0] error_offset;

  mode_t         lex_mode;
  logic          lex_dq;
  logic [2:0]    lex_hex_left;
  logic          lex_under;
  logic [1:0]    lex_sep;
  logic [CW-1:0] lex_count;

  scan_report_t reports_due [$];
  plan_item_t   text_plan [$];

  int plan_count = 0;
  int bytes_sent = 0;
  int words_checked = 0;
  int mismatches = 0;
  int n_done = 0;
  int n_term = 0;
  int n_badhex = 0;
  int n_notlit = 0;
  int tx_gap_pct = 25;
  int tx_quiet = 0;
  int rx_stall_pct = 25;
  int rx_stall_left = 0;
  int rx_quiet = 0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  dir_row_t dir_rows [27] = '{
    '{"a",        1'b0, 1'b1, ST_IDLE,   16'd0, 16'd0},
    '{8'hff,      1'b1, 1'b1, ST_NOTLIT, 16'd0, 16'd0},
    '{CH_DQUOTE,  1'b1, 1'b1, ST_SCAN,   16'd0, 16'd0},
    '{CH_BSLASH,  1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_LOWER_U, 1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_LBRACE,  1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_UNDER,   1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_UNDER,   1'b0, 1'b1, ST_BADHEX, 16'd0, 16'd5},
    '{CH_SQUOTE,  1'b1, 1'b1, ST_SCAN,   16'd0, 16'd0},
    '{CH_BSLASH,  1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_LOWER_U, 1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{"F",        1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{"0",        1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{"z",        1'b0, 1'b1, ST_BADHEX, 16'd0, 16'd5},
    '{CH_DQUOTE,  1'b1, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{SEP_LEAD,   1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{SEP_MID,    1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{SEP_LS,     1'b0, 1'b1, ST_TERM,   16'd0, 16'd1},
    '{CH_DQUOTE,  1'b1, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_BSLASH,  1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_NUL,     1'b0, 1'b1, ST_TERM,   16'd0, 16'd2},
    '{CH_SQUOTE,  1'b1, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{"x",        1'b0, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_DQUOTE,  1'b1, 1'b1, ST_SCAN,   16'd0, 16'd0},
    '{CH_CR,      1'b0, 1'b1, ST_TERM,   16'd0, 16'd1},
    '{CH_SQUOTE,  1'b1, 1'b0, ST_IDLE,   16'd0, 16'd0},
    '{CH_SQUOTE,  1'b0, 1'b1, ST_DONE,   16'd2, 16'd0}
  };

  string_literal_scanner i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .starts_token (starts_token),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scan_status  (scan_status),
    .token_length (token_length),
    .error_offset (error_offset)
  );

  always #5 clk = ~clk;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic [15:0] clip16(input logic [CW:0] v);
    return (v > 'hffff) ? 16'hffff : v[15:0];
  endfunction

  function automatic void lex_restart();
    lex_mode = MODE_IDLE;
    lex_hex_left = 3'd0;
    lex_under = 1'b0;
    lex_sep = 2'd0;
    lex_count = '0;
  endfunction

  function automatic scan_report_t lex_byte(input logic [7:0] b, input logic starts);
    scan_report_t w;
    logic         ends;
    logic [CW:0]  pos;
    logic [CW:0]  len_v;
    w = '{ST_IDLE, 16'd0, 16'd0};
    ends = 1'b0;
    pos = {1'b0, lex_count};
    if (starts) begin
      lex_restart();
      if (b == CH_SQUOTE || b == CH_DQUOTE) begin
        lex_mode = MODE_BODY;
        lex_dq = (b == CH_DQUOTE);
        lex_count = CW'(1);
        w.status = ST_SCAN;
      end else begin
        w.status = ST_NOTLIT;
      end
    end else if (lex_mode != MODE_IDLE) begin
      w.status = ST_SCAN;
      case (lex_mode)
        MODE_BODY: begin
          if (b == CH_LF || b == CH_CR || b == CH_NUL) begin
            w.status = ST_TERM;
            w.err_off = clip16(pos);
            ends = 1'b1;
          end else if (lex_sep == 2'd2 && (b == SEP_LS || b == SEP_PS)) begin
            w.status = ST_TERM;
            w.err_off = clip16((pos >= (CW+1)'(2)) ? pos - (CW+1)'(2) : '0);
            ends = 1'b1;
          end else if (b == CH_BSLASH) begin
            lex_mode = MODE_ESC;
            lex_sep = 2'd0;
          end else if (b == (lex_dq ? CH_DQUOTE : CH_SQUOTE)) begin
            len_v = pos + 1'b1;
            if (len_v > {1'b0, CNT_MAX}) len_v = {1'b0, CNT_MAX};
            w.status = ST_DONE;
            w.tok_len = clip16(len_v);
            ends = 1'b1;
          end else if (b == SEP_LEAD) begin
            lex_sep = 2'd1;
          end else if (lex_sep == 2'd1 && b == SEP_MID) begin
            lex_sep = 2'd2;
          end else begin
            lex_sep = 2'd0;
          end
        end
        MODE_ESC: begin
          if (b == CH_NUL) begin
            w.status = ST_TERM;
            w.err_off = clip16(pos);
            ends = 1'b1;
          end else if (b == CH_LOWER_U) begin
            lex_mode = MODE_UOPEN;
          end else if (b == CH_LOWER_X) begin
            lex_mode = MODE_FIXED;
            lex_hex_left = 3'd2;
          end else begin
            lex_mode = MODE_BODY;
          end
        end
        MODE_UOPEN: begin
          if (b == CH_LBRACE) begin
            lex_mode = MODE_BRACE;
            lex_under = 1'b0;
          end else if (is_hex(b)) begin
            lex_mode = MODE_FIXED;
            lex_hex_left = 3'd3;
          end else begin
            w.status = ST_BADHEX;
            w.err_off = clip16(pos);
            ends = 1'b1;
          end
        end
        MODE_BRACE: begin
          if (is_hex(b)) begin
            lex_under = 1'b0;
          end else if (b == CH_UNDER && !lex_under) begin
            lex_under = 1'b1;
          end else if (b == CH_RBRACE) begin
            lex_mode = MODE_BODY;
            lex_under = 1'b0;
          end else begin
            w.status = ST_BADHEX;
            w.err_off = clip16(pos);
            ends = 1'b1;
          end
        end
        MODE_FIXED: begin
          if (!is_hex(b)) begin
            w.status = ST_BADHEX;
            w.err_off = clip16(pos);
            ends = 1'b1;
          end else if (lex_hex_left <= 3'd1) begin
            lex_hex_left = 3'd0;
            lex_mode = MODE_BODY;
          end else begin
            lex_hex_left = lex_hex_left - 3'd1;
          end
        end
        default: begin
          w.status = ST_IDLE;
          ends = 1'b1;
        end
      endcase
      if (ends) lex_restart();
      else if (lex_count != CNT_MAX) lex_count = lex_count + 1'b1;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] hex_or_bad();
    int v;
    v = $urandom_range(0, 23);
    if (v >= 22) return any_byte();
    if (v < 10) return 8'("0" + v);
    if (v < 16) return 8'("a" + v - 10);
    return 8'("A" + v - 16);
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7e));
    if (c == CH_DQUOTE || c == CH_SQUOTE || c == CH_BSLASH) c = "a";
    return c;
  endfunction

  function automatic void plan_byte(input logic [7:0] ch, input logic starts);
    text_plan.push_back('{ch, starts});
    plan_count++;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 20) $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic send_byte(input logic [7:0] ch, input logic starts, input logic typed,
                           input scan_report_t fixed);
    int           gap;
    scan_report_t w;
    gap = 0;
    if (tx_quiet > 0) tx_quiet--;
    else if ($urandom_range(0, 199) == 0) tx_quiet = $urandom_range(20, 120);
    else if ($urandom_range(0, 99) < tx_gap_pct) gap = pick_gap();
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid <= 1'b1;
    text_byte <= ch;
    starts_token <= starts;
    do @(posedge clk); while (text_stall);
    w = lex_byte(ch, starts);
    if (typed) w = fixed;
    reports_due.push_back(w);
    bytes_sent++;
  endtask

  task automatic send_plan();
    plan_item_t it;
    while (text_plan.size() != 0) begin
      it = text_plan.pop_front();
      send_byte(it.ch, it.starts, 1'b0, '0);
    end
  endtask

  task automatic drain_wait();
    text_valid <= 1'b0;
    do @(posedge clk); while (reports_due.size() != 0);
  endtask

  // check result words and drive the result-side stall
  always @(posedge clk) begin
    scan_report_t e;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (reports_due.size() == 0) begin
          report_mismatch($sformatf("unexpected word status %0d", scan_status));
        end else begin
          e = reports_due.pop_front();
          if (scan_status !== e.status)
            report_mismatch($sformatf("word %0d: status %0d, want %0d",
                                      words_checked, scan_status, e.status));
          if (token_length !== e.tok_len)
            report_mismatch($sformatf("word %0d: length %0d, want %0d",
                                      words_checked, token_length, e.tok_len));
          if (error_offset !== e.err_off)
            report_mismatch($sformatf("word %0d: offset %0d, want %0d",
                                      words_checked, error_offset, e.err_off));
          if (e.status == ST_DONE) n_done++;
          if (e.status == ST_TERM) n_term++;
          if (e.status == ST_BADHEX) n_badhex++;
          if (e.status == ST_NOTLIT) n_notlit++;
          words_checked++;
        end
      end
      if (!hold_done && words_checked >= 300) begin
        hold_done = 1'b1;
        rx_stall_left = HOLD_OFF_CYCLES;
      end
      if (rx_stall_left > 0) begin
        result_stall <= 1'b1;
        rx_stall_left--;
      end else begin
        result_stall <= 1'b0;
        if (rx_quiet > 0) rx_quiet--;
        else if ($urandom_range(0, 299) == 0) rx_quiet = $urandom_range(40, 160);
        else if ($urandom_range(0, 99) < rx_stall_pct) rx_stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (text_valid && !text_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t   row;
    logic [7:0] q;
    int         pick;
    lex_restart();
    lex_dq = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_byte(row.ch, row.starts, row.typed, '{row.status, row.tok_len, row.err_off});
    end
    drain_wait();

    // random literals in two halves, pausing for the scanner to drain between them
    for (int half = 0; half < 2; half++) begin
      while (plan_count < 650 * (half + 1)) begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        plan_byte(q, 1'b1);
        repeat ($urandom_range(0, 12)) begin
          case ($urandom_range(0, 11))
            4: plan_byte((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE, 1'b0);
            5: plan_byte(any_byte(), 1'b0);
            6: begin
              plan_byte(CH_BSLASH, 1'b0);
              plan_byte(CH_LOWER_X, 1'b0);
              repeat (2) plan_byte(hex_or_bad(), 1'b0);
            end
            7: begin
              plan_byte(CH_BSLASH, 1'b0);
              plan_byte(CH_LOWER_U, 1'b0);
              repeat (4) plan_byte(hex_or_bad(), 1'b0);
            end
            8: begin
              plan_byte(CH_BSLASH, 1'b0);
              plan_byte(CH_LOWER_U, 1'b0);
              plan_byte(CH_LBRACE, 1'b0);
              repeat ($urandom_range(0, 6))
                plan_byte(($urandom_range(0, 2) == 0) ? CH_UNDER : hex_or_bad(), 1'b0);
              plan_byte(($urandom_range(0, 15) == 0) ? any_byte() : CH_RBRACE, 1'b0);
            end
            9: begin
              plan_byte(CH_BSLASH, 1'b0);
              plan_byte(any_byte(), 1'b0);
            end
            10: begin
              plan_byte(SEP_LEAD, 1'b0);
              if ($urandom_range(0, 3) != 0) plan_byte(SEP_MID, 1'b0);
              pick = $urandom_range(0, 3);
              plan_byte((pick == 0) ? SEP_LS : (pick == 1) ? SEP_PS :
                        (pick == 2) ? q : any_byte(), 1'b0);
            end
            11: plan_byte(8'($urandom_range(8'h80, 8'hff)), 1'b0);
            default: plan_byte(plain_char(), 1'b0);
          endcase
        end
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          pick = $urandom_range(0, 2);
          plan_byte((pick == 0) ? CH_LF : (pick == 1) ? CH_CR : CH_NUL, 1'b0);
        end else if (pick != 1) begin
          plan_byte(q, 1'b0);
        end
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) plan_byte(any_byte(), 1'b0);
        if ($urandom_range(0, 15) == 0) plan_byte(any_byte(), 1'b1);
      end
      send_plan();
      drain_wait();
    end

    // long literals ending in a quote, a separator and a bad escape
    tx_gap_pct = 3;
    rx_stall_pct = 3;
    for (int k = 0; k < 3; k++) begin
      plan_byte((k == 1) ? CH_SQUOTE : CH_DQUOTE, 1'b1);
      repeat (120) plan_byte(plain_char(), 1'b0);
      case (k)
        0: plan_byte(CH_DQUOTE, 1'b0);
        1: begin
          plan_byte(SEP_LEAD, 1'b0);
          plan_byte(SEP_MID, 1'b0);
          plan_byte(SEP_PS, 1'b0);
        end
        default: begin
          plan_byte(CH_BSLASH, 1'b0);
          plan_byte(CH_LOWER_X, 1'b0);
          plan_byte("q", 1'b0);
        end
      endcase
      send_plan();
    end
    drain_wait();
    repeat (6) @(posedge clk);

    $display("Sent %0d bytes, checked %0d status words; three long literals at the end",
             bytes_sent, words_checked);
    $display("Closed literals %0d, raw terminators %0d, bad escapes %0d, rejected starts %0d",
             n_done, n_term, n_badhex, n_notlit);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
